>>> rtl/core/assert_macros.svh
// assertion helpers used by sorted_priority_queue_unit
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// property that must hold at every clock edge outside reset
`define SPQ_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// when ante holds, cons must hold in the next cycle
`define SPQ_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`else

`define SPQ_ASSERT(label, clk, rst, prop, msg)
`define SPQ_ASSERT_NEXT(label, clk, rst, ante, cons, msg)

`endif

`endif

>>> rtl/core/spq_pkg.sv
package spq_pkg;

   localparam int CAPACITY = 16;
   localparam int COUNT_W  = $clog2(CAPACITY + 1);
   localparam int DATA_W   = 32;
   localparam int PRIO_W   = 16;
   localparam int OP_W     = 2;
   localparam int STATUS_W = 2;
   localparam int OCC_W    = 5;

   localparam logic [OP_W-1:0] OP_INSERT  = 2'd0;
   localparam logic [OP_W-1:0] OP_DEQUEUE = 2'd1;
   localparam logic [OP_W-1:0] OP_PEEK    = 2'd2;

   localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] ST_UNDERFLOW = 2'd1;
   localparam logic [STATUS_W-1:0] ST_OVERFLOW  = 2'd2;

   localparam logic [DATA_W-1:0] EMPTY_PEEK = '1;

   typedef struct packed {
      logic [DATA_W-1:0] data;
      logic [PRIO_W-1:0] prio;
   } entry_type;

   // command broadcast to every cell of the chain
   typedef struct packed {
      logic      insert;
      logic      remove;
      entry_type item;
   } cell_cmd_type;

endpackage

>>> rtl/core/spq_if.sv
interface spq_req_if;
   logic                                valid;
   logic                                ready;
   logic [spq_pkg::OP_W-1:0]            op;
   logic signed [spq_pkg::DATA_W-1:0]   item_data;
   logic [spq_pkg::PRIO_W-1:0]          item_priority;

   modport source (output valid, output op, output item_data, output item_priority,
                   input ready);
   modport sink   (input valid, input op, input item_data, input item_priority,
                   output ready);
endinterface

interface spq_rsp_if;
   logic                                valid;
   logic                                ready;
   logic signed [spq_pkg::DATA_W-1:0]   head_data;
   logic [spq_pkg::STATUS_W-1:0]        status;
   logic [spq_pkg::OCC_W-1:0]           occupancy;

   modport source (output valid, output head_data, output status, output occupancy,
                   input ready);
   modport sink   (input valid, input head_data, input status, input occupancy,
                   output ready);
endinterface

>>> rtl/core/sorted_priority_queue_unit.sv
// Sorted priority queue of spq_pkg::CAPACITY entries, lowest priority number at the head.
// Each transaction on req is one operation: insert (item placed ahead of the first entry
// whose priority is equal or greater, so ties leave newest first), dequeue of the head,
// or peek of the head's data word (-1 when empty). Every request yields exactly one
// transaction on rsp with head_data, status (ok, underflow, overflow) and the occupancy
// after the operation. Throughput is one operation per cycle while the receiver keeps up:
// the whole queue is a row of cells that all compare against the new priority and shift
// by one place in the same cycle, and the result sits in an output register. The next
// request goes in at the edge where the previous result is taken; a result held by a
// stalled receiver holds off the input. Entry storage has no reset; only the fill count
// and the response valid flag clear.
`include "assert_macros.svh"

module sorted_priority_queue_unit (
   input logic       clock,
   input logic       reset,
   spq_req_if.sink   req,
   spq_rsp_if.source rsp
);

   localparam int CAP = spq_pkg::CAPACITY;
   localparam int CW  = spq_pkg::COUNT_W;

   // fill count and response register
   logic [CW-1:0]                   count_ff;
   logic [CW-1:0]                   count_in;
   logic                            rsp_valid_ff;
   logic                            rsp_valid_in;
   logic [spq_pkg::DATA_W-1:0]      head_ff;
   logic [spq_pkg::DATA_W-1:0]      head_in;
   logic [spq_pkg::STATUS_W-1:0]    status_ff;
   logic [spq_pkg::STATUS_W-1:0]    status_in;

   logic                  req_fire;
   logic                  is_empty;
   logic                  is_full;
   spq_pkg::cell_cmd_type cmd;

   // cell chain wiring
   spq_pkg::entry_type cell_entry [CAP];
   spq_pkg::entry_type cell_left  [CAP];
   spq_pkg::entry_type cell_right [CAP];
   logic               cell_less  [CAP];
   logic               cell_lless [CAP];
   logic               cell_occ   [CAP];

   // a new request goes in whenever the output slot frees up this cycle
   assign req.ready = !rsp_valid_ff || rsp.ready;
   assign req_fire  = req.valid && req.ready;

   assign is_empty = (count_ff == '0);
   assign is_full  = (count_ff == CW'(CAP));

   // the broadcast command; full inserts and empty dequeues leave the chain alone
   always_comb begin
      cmd.insert    = req_fire && (req.op == spq_pkg::OP_INSERT) && !is_full;
      cmd.remove    = req_fire && (req.op == spq_pkg::OP_DEQUEUE) && !is_empty;
      cmd.item.data = req.item_data;
      cmd.item.prio = req.item_priority;
   end

   for (genvar i = 0; i < CAP; i++) begin : g_cell
      assign cell_occ[i] = (CW'(i) < count_ff);

      // head cell sees an always-less neighbor, so a new item may land there
      if (i == 0) begin : g_head
         assign cell_left[i]  = '0;
         assign cell_lless[i] = 1'b1;
      end else begin : g_body
         assign cell_left[i]  = cell_entry[i-1];
         assign cell_lless[i] = cell_less[i-1];
      end

      // tail cell pulls in a don't-care entry; the count marks it empty
      if (i == CAP - 1) begin : g_tail
         assign cell_right[i] = '0;
      end else begin : g_mid
         assign cell_right[i] = cell_entry[i+1];
      end

      spq_cell u_cell (
         .clock       (clock),
         .cmd         (cmd),
         .occupied    (cell_occ[i]),
         .left_entry  (cell_left[i]),
         .left_less   (cell_lless[i]),
         .right_entry (cell_right[i]),
         .entry       (cell_entry[i]),
         .less        (cell_less[i])
      );
   end

   // next count and response contents
   always_comb begin
      count_in     = count_ff;
      rsp_valid_in = rsp_valid_ff;
      head_in      = head_ff;
      status_in    = status_ff;
      if (rsp_valid_ff && rsp.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.insert) begin
         count_in = count_ff + CW'(1);
      end else if (cmd.remove) begin
         count_in = count_ff - CW'(1);
      end
      if (req_fire) begin
         rsp_valid_in = 1'b1;
         head_in      = '0;
         status_in    = spq_pkg::ST_OK;
         unique case (req.op)
            spq_pkg::OP_INSERT: begin
               if (is_full) begin
                  status_in = spq_pkg::ST_OVERFLOW;
               end
            end
            spq_pkg::OP_DEQUEUE: begin
               if (is_empty) begin
                  status_in = spq_pkg::ST_UNDERFLOW;
               end
            end
            spq_pkg::OP_PEEK: begin
               if (is_empty) begin
                  head_in   = spq_pkg::EMPTY_PEEK;
                  status_in = spq_pkg::ST_UNDERFLOW;
               end else begin
                  head_in = cell_entry[0].data;
               end
            end
            default: begin
               // unused code: no operation, ok status
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      head_ff   <= head_in;
      status_ff <= status_in;
   end

   // occupancy after the operation is the count once it has settled
   logic [spq_pkg::OCC_W-1:0] occ_ff;
   always_ff @(posedge clock) begin
      if (req_fire) begin
         occ_ff <= spq_pkg::OCC_W'(count_in);
      end
   end

   assign rsp.valid     = rsp_valid_ff;
   assign rsp.head_data = head_ff;
   assign rsp.status    = status_ff;
   assign rsp.occupancy = occ_ff;

   `SPQ_ASSERT(a_count_bound, clock, reset, count_ff <= CW'(CAP), "fill count above capacity")
   `SPQ_ASSERT_NEXT(a_insert_grows, clock, reset, cmd.insert,
      count_ff == $past(count_ff) + CW'(1), "insert did not grow the queue")
   `SPQ_ASSERT_NEXT(a_remove_shrinks, clock, reset, cmd.remove,
      count_ff == $past(count_ff) - CW'(1), "dequeue did not shrink the queue")
   `SPQ_ASSERT(a_overflow_full, clock, reset,
      !(rsp_valid_ff && status_ff == spq_pkg::ST_OVERFLOW) || occ_ff == spq_pkg::OCC_W'(CAP),
      "overflow reported on a queue that was not full")

endmodule

>>> rtl/core/spq_cell.sv
module spq_cell (
   input  logic                 clock,
   input  spq_pkg::cell_cmd_type cmd,
   input  logic                 occupied,
   input  spq_pkg::entry_type   left_entry,
   input  logic                 left_less,
   input  spq_pkg::entry_type   right_entry,
   output spq_pkg::entry_type   entry,
   output logic                 less
);

   spq_pkg::entry_type entry_ff;
   spq_pkg::entry_type entry_in;

   // held entry sorts ahead of the incoming item
   assign less  = occupied && (entry_ff.prio < cmd.item.prio);
   assign entry = entry_ff;

   always_comb begin
      entry_in = entry_ff;
      if (cmd.insert) begin
         if (!less) begin
            entry_in = left_less ? cmd.item : left_entry;
         end
      end else if (cmd.remove) begin
         entry_in = right_entry;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

endmodule
